// ----- sv/bpc_pkg.sv -----
// shared types and constants for the button press classifier
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int TIME_BITS = 32;
  localparam int THR_BITS  = 16;
  localparam int IDX_BITS  = 3;

  typedef logic [TIME_BITS-1:0] stamp_t;
  typedef logic [THR_BITS-1:0]  thr_t;

  // register indexes on the configuration port
  localparam logic [IDX_BITS-1:0] REG_REPEAT_ENABLE = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_DEBOUNCE      = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_SHORT_MAX     = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_LONG          = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_REPEAT_START  = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_REPEAT_PERIOD = 3'd5;

  localparam thr_t DEBOUNCE_RST      = 16'd25;
  localparam thr_t SHORT_MAX_RST     = 16'd500;
  localparam thr_t LONG_RST          = 16'd600;
  localparam thr_t REPEAT_START_RST  = 16'd1000;
  localparam thr_t REPEAT_PERIOD_RST = 16'd250;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SHORT  = 2'd1,
    ACT_LONG   = 2'd2,
    ACT_REPEAT = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'b00001,
    PH_DEB_PRESS   = 5'b00010,
    PH_HELD        = 5'b00100,
    PH_LONG        = 5'b01000,
    PH_DEB_RELEASE = 5'b10000
  } phase_t;

  typedef struct packed {
    logic repeat_enable;
    thr_t debounce_time;
    thr_t short_max_time;
    thr_t long_time;
    thr_t repeat_start_time;
    thr_t repeat_period;
  } cfg_t;

endpackage

// ----- sv/bpc_cfg.sv -----
// threshold and enable registers behind the write port
`timescale 1ns / 1ps

module bpc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [bpc_pkg::IDX_BITS-1:0] cfg_index,
  input  bpc_pkg::thr_t                cfg_data,
  output bpc_pkg::cfg_t                cfg
);
  import bpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_enable     <= 1'b0;
      cfg.debounce_time     <= DEBOUNCE_RST;
      cfg.short_max_time    <= SHORT_MAX_RST;
      cfg.long_time         <= LONG_RST;
      cfg.repeat_start_time <= REPEAT_START_RST;
      cfg.repeat_period     <= REPEAT_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REPEAT_ENABLE: cfg.repeat_enable     <= cfg_data[0];
        REG_DEBOUNCE:      cfg.debounce_time     <= cfg_data;
        REG_SHORT_MAX:     cfg.short_max_time    <= cfg_data;
        REG_LONG:          cfg.long_time         <= cfg_data;
        REG_REPEAT_START:  cfg.repeat_start_time <= cfg_data;
        REG_REPEAT_PERIOD: cfg.repeat_period     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/bpc_core.sv -----
// input register and press classification state machine
`timescale 1ns / 1ps

module bpc_core (
  input  logic             clk,
  input  logic             rst,
  input  bpc_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             pressed,
  input  bpc_pkg::stamp_t  time_now,
  input  logic             take_ok,
  output logic             res_valid,
  output bpc_pkg::action_t res_action
);
  import bpc_pkg::*;

  logic   s1_valid;
  logic   s1_pressed;
  stamp_t s1_time;
  logic   fire;

  phase_t  phase, phase_next;
  stamp_t  edge_time, edge_time_next;
  stamp_t  press_start, press_start_next;
  stamp_t  last_repeat, last_repeat_next;
  logic    long_done, long_done_next;
  logic    short_waiting, short_waiting_next;
  action_t act;

  stamp_t since_edge, held, since_repeat;
  logic   edge_ok, held_deb, held_short, held_long, held_rep, rep_ok;

  assign fire     = s1_valid && take_ok;
  assign in_stall = s1_valid && !take_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pressed <= pressed;
      s1_time    <= time_now;
    end
  end

  // elapsed times wrap with the timestamp
  assign since_edge   = s1_time - edge_time;
  assign held         = s1_time - press_start;
  assign since_repeat = s1_time - last_repeat;

  assign edge_ok    = since_edge   >= stamp_t'(cfg.debounce_time);
  assign held_deb   = held         >= stamp_t'(cfg.debounce_time);
  assign held_short = held         <  stamp_t'(cfg.short_max_time);
  assign held_long  = held         >= stamp_t'(cfg.long_time);
  assign held_rep   = held         >= stamp_t'(cfg.repeat_start_time);
  assign rep_ok     = since_repeat >= stamp_t'(cfg.repeat_period);

  always_comb begin
    phase_next         = phase;
    edge_time_next     = edge_time;
    press_start_next   = press_start;
    last_repeat_next   = last_repeat;
    long_done_next     = long_done;
    short_waiting_next = short_waiting;
    act                = ACT_NONE;
    unique case (phase)
      PH_DEB_PRESS: begin
        if (edge_ok) begin
          phase_next = s1_pressed ? PH_HELD : PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!s1_pressed) begin
          edge_time_next = s1_time;
          if (held_deb) begin
            short_waiting_next = held_short;
            phase_next         = PH_DEB_RELEASE;
          end else begin
            phase_next = PH_IDLE;
          end
        end else if (held_long && !long_done) begin
          act              = ACT_LONG;
          long_done_next   = 1'b1;
          phase_next       = PH_LONG;
          last_repeat_next = s1_time;
        end
      end
      PH_LONG: begin
        if (!s1_pressed) begin
          edge_time_next     = s1_time;
          short_waiting_next = 1'b0;
          phase_next         = PH_DEB_RELEASE;
        end else if (cfg.repeat_enable && held_rep && rep_ok) begin
          act              = ACT_REPEAT;
          last_repeat_next = s1_time;
        end
      end
      PH_DEB_RELEASE: begin
        if (edge_ok) begin
          if (!s1_pressed) begin
            if (short_waiting) begin
              act                = ACT_SHORT;
              short_waiting_next = 1'b0;
            end
            phase_next = PH_IDLE;
          end else begin
            // bounce cancels the pending short
            short_waiting_next = 1'b0;
            phase_next         = long_done ? PH_LONG : PH_HELD;
          end
        end
      end
      default: begin
        if (s1_pressed) begin
          phase_next         = PH_DEB_PRESS;
          press_start_next   = s1_time;
          edge_time_next     = s1_time;
          long_done_next     = 1'b0;
          short_waiting_next = 1'b0;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      edge_time     <= '0;
      press_start   <= '0;
      last_repeat   <= '0;
      long_done     <= 1'b0;
      short_waiting <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      edge_time     <= edge_time_next;
      press_start   <= press_start_next;
      last_repeat   <= last_repeat_next;
      long_done     <= long_done_next;
      short_waiting <= short_waiting_next;
    end
  end

  assign res_valid  = fire;
  assign res_action = act;

endmodule

// ----- sv/bpc_out.sv -----
// result register on the output channel
`timescale 1ns / 1ps

module bpc_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  bpc_pkg::action_t res_action,
  output logic             take_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       action
);
  import bpc_pkg::*;

  action_t action_reg;

  assign take_ok = !out_valid || !out_stall;
  assign action  = action_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_ok) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ok && res_valid) begin
      action_reg <= res_action;
    end
  end

endmodule

// ----- sv/button_press_classifier_top.sv -----
// top level of the debounced button press classifier
//
//   channel   handshake            payload
//   in        in_valid / in_stall  pressed, time_now
//   out       out_valid / out_stall action
//   cfg       cfg_write            cfg_index, cfg_data
//
// one item per clock while the output is not stalled; each item is held in the input
// register, where the state machine classifies it, and leaves from the result register
// a result becomes valid once the result register takes it from the input register
// reset returns the machine to idle and the thresholds to their defaults
// a stalled output holds the result and backs up into in_stall the same cycle
`timescale 1ns / 1ps

module button_press_classifier_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         pressed,
  input  bpc_pkg::stamp_t              time_now,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   action,
  input  logic                         cfg_write,
  input  logic [bpc_pkg::IDX_BITS-1:0] cfg_index,
  input  bpc_pkg::thr_t                cfg_data
);
  import bpc_pkg::*;

  cfg_t    cfg;
  logic    take_ok;
  logic    res_valid;
  action_t res_action;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pressed    (pressed),
    .time_now   (time_now),
    .take_ok    (take_ok),
    .res_valid  (res_valid),
    .res_action (res_action)
  );

  bpc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_action (res_action),
    .take_ok    (take_ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .action     (action)
  );

endmodule

// ----- bench/button_press_classifier_top_tb.sv -----
// self-checking bench for the button press classifier: directed gestures, then random ones
`timescale 1ns / 1ps

module button_press_classifier_top_tb;
  import bpc_pkg::*;

  localparam int LATENCY         = 2;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;

  // indexes past the last register, writes there must be dropped
  localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic                pressed   = 1'b0;
  stamp_t              time_now  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          action;
  logic                cfg_write = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  thr_t                cfg_data  = '0;

  // mirror of the thresholds and of the classifier state
  cfg_t   regs = '{1'b0, DEBOUNCE_RST, SHORT_MAX_RST, LONG_RST, REPEAT_START_RST,
                   REPEAT_PERIOD_RST};
  phase_t ph           = PH_IDLE;
  stamp_t edge_ms      = '0;
  stamp_t press_ms     = '0;
  stamp_t repeat_ms    = '0;
  logic   long_latched = 1'b0;
  logic   short_armed  = 1'b0;

  action_t     pending_actions[$];
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  stamp_t      now_ms      = '0;
  bit          tx_idle_on  = 1'b0;
  bit          rx_idle_on  = 1'b0;
  bit          hold_req    = 1'b0;

  button_press_classifier_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pressed   (pressed),
    .time_now  (time_now),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .action    (action),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic stamp_t ms_between(stamp_t later, stamp_t earlier);
    return later - earlier;
  endfunction

  function automatic action_t classify_sample(logic lvl, stamp_t now);
    action_t act;
    stamp_t  held;
    act  = ACT_NONE;
    held = ms_between(now, press_ms);
    case (ph)
      PH_DEB_PRESS: begin
        if (ms_between(now, edge_ms) >= stamp_t'(regs.debounce_time))
          ph = lvl ? PH_HELD : PH_IDLE;
      end
      PH_HELD: begin
        if (!lvl) begin
          edge_ms = now;
          if (held >= stamp_t'(regs.debounce_time)) begin
            short_armed = held < stamp_t'(regs.short_max_time);
            ph = PH_DEB_RELEASE;
          end else begin
            ph = PH_IDLE;
          end
        end else if (held >= stamp_t'(regs.long_time) && !long_latched) begin
          act          = ACT_LONG;
          long_latched = 1'b1;
          ph           = PH_LONG;
          repeat_ms    = now;
        end
      end
      PH_LONG: begin
        if (!lvl) begin
          edge_ms     = now;
          short_armed = 1'b0;
          ph          = PH_DEB_RELEASE;
        end else if (regs.repeat_enable && held >= stamp_t'(regs.repeat_start_time) &&
                     ms_between(now, repeat_ms) >= stamp_t'(regs.repeat_period)) begin
          act       = ACT_REPEAT;
          repeat_ms = now;
        end
      end
      PH_DEB_RELEASE: begin
        if (ms_between(now, edge_ms) >= stamp_t'(regs.debounce_time)) begin
          if (!lvl) begin
            if (short_armed) act = ACT_SHORT;
            ph = PH_IDLE;
          end else begin
            ph = long_latched ? PH_LONG : PH_HELD;
          end
          short_armed = 1'b0;
        end
      end
      default: begin
        if (lvl) begin
          ph           = PH_DEB_PRESS;
          press_ms     = now;
          edge_ms      = now;
          long_latched = 1'b0;
          short_armed  = 1'b0;
        end
      end
    endcase
    return act;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic thr_t pick_thr(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return thr_t'($urandom);
    return thr_t'($urandom_range(lo, hi));
  endfunction

  // predict on every accepted item
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) pending_actions.push_back(classify_sample(pressed, time_now));
  end

  always @(posedge clk) begin : check_actions
    action_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_actions.size() == 0) begin
        $display("%0t unexpected action: expected none, got %0d", $time, action);
        mismatches++;
      end else begin
        want = pending_actions.pop_front();
        if (action !== want) begin
          $display("%0t action mismatch: expected %0d (%s), got %0d", $time, want, want.name(),
                   action);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[button_press_classifier_top] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, and one long hold-off on request
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        n = rx_idle_on ? pick_gap() : 0;
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic lvl, stamp_t t);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pressed  <= lvl;
    time_now <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // sender holds back until every outstanding action has come out
  task automatic sender_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_actions.size() != 0) @(posedge clk);
  endtask

  task automatic go_idle();
    sender_pause();
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  task automatic tick(logic lvl, stamp_t dt);
    now_ms += dt;
    if ($urandom_range(0, 299) == 0) sender_pause();
    send_item(lvl, now_ms);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, thr_t data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_REPEAT_ENABLE: regs.repeat_enable     = data[0];
      REG_DEBOUNCE:      regs.debounce_time     = data;
      REG_SHORT_MAX:     regs.short_max_time    = data;
      REG_LONG:          regs.long_time         = data;
      REG_REPEAT_START:  regs.repeat_start_time = data;
      REG_REPEAT_PERIOD: regs.repeat_period     = data;
      default: ;
    endcase
  endtask

  task automatic program_all(thr_t en, thr_t dbt, thr_t smax, thr_t lng, thr_t rs, thr_t per);
    write_reg(REG_REPEAT_ENABLE, en);
    write_reg(REG_DEBOUNCE, dbt);
    write_reg(REG_SHORT_MAX, smax);
    write_reg(REG_LONG, lng);
    write_reg(REG_REPEAT_START, rs);
    write_reg(REG_REPEAT_PERIOD, per);
  endtask

  task automatic release_tail(int unsigned dbt);
    int unsigned into;
    int unsigned r;
    tick(1'b0, $urandom_range(0, 3));
    into = 0;
    r = $urandom_range(0, 9);
    if (dbt > 1 && r < 3) begin
      into = $urandom_range(1, dbt - 1);
      tick($urandom_range(0, 1) == 1, into);
    end
    if (r == 9) begin
      // level back up when the window closes, then a second release
      tick(1'b1, dbt + $urandom_range(0, 2));
      tick(1'b1, $urandom_range(1, 50));
      tick(1'b0, $urandom_range(0, 3));
    end
    tick(1'b0, dbt - into + $urandom_range(0, 2));
  endtask

  // one press and release shaped around the current thresholds
  task automatic press_gesture();
    int unsigned dbt, smax, lng, rs, per;
    int unsigned hold, off, stride, d, n, bucket;
    dbt    = regs.debounce_time;
    smax   = regs.short_max_time;
    lng    = regs.long_time;
    rs     = regs.repeat_start_time;
    per    = regs.repeat_period;
    bucket = $urandom_range(0, 5);
    case (bucket)
      1: hold = dbt + $urandom_range(0, (smax > dbt) ? smax - dbt - 1 : 0);
      2: hold = smax + $urandom_range(0, (lng > smax) ? lng - smax : 20);
      3: hold = lng + $urandom_range(0, 100);
      4: hold = ((lng > rs) ? lng : rs) + per * $urandom_range(1, 6) + $urandom_range(0, per);
      default: hold = $urandom_range(0, 2 * lng + dbt + 10);
    endcase
    repeat ($urandom_range(0, 2)) tick(1'b0, $urandom_range(1, 40));
    tick(1'b1, $urandom_range(1, 40));
    off = 0;
    // level inside the press window is ignored
    if (dbt > 1 && $urandom_range(0, 1) == 1) begin
      off = $urandom_range(1, dbt - 1);
      tick($urandom_range(0, 1) == 1, off);
    end
    d = dbt - off + $urandom_range(0, 2);
    // bucket 0 is low once the window closes: a glitch
    tick(bucket != 0, d);
    off += d;
    if (bucket == 0) return;
    n      = $urandom_range(1, (bucket == 4) ? 30 : 10);
    stride = (hold > off) ? (hold - off) / n : 0;
    if (stride == 0) stride = 1;
    while (off + stride < hold) begin
      d = stride + $urandom_range(0, stride / 4);
      tick(1'b1, d);
      off += d;
    end
    release_tail(dbt);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 3) == 0) now_ms = $urandom;
      else now_ms += $urandom_range(0, 100);
      send_item($urandom_range(0, 1) == 1, now_ms);
    end
  endtask

  task automatic test_defaults();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // short press with a low sample inside the press window
    tick(1'b1, 0);  tick(1'b0, 10); tick(1'b1, 15); tick(1'b0, 75); tick(1'b0, 25);
    // release in the dead zone between short and long
    tick(1'b1, 5);  tick(1'b1, 25); tick(1'b0, 520); tick(1'b0, 25);
    // long press, level returns while the release settles
    tick(1'b1, 5);  tick(1'b1, 25); tick(1'b1, 575); tick(1'b0, 100);
    tick(1'b1, 25); tick(1'b0, 10); tick(1'b0, 25);
    // press glitch
    tick(1'b1, 5);  tick(1'b0, 25);
    // release stamped before the debounce time has passed since the press
    tick(1'b1, 5);  tick(1'b1, 25); tick(1'b0, stamp_t'(-20));
  endtask

  task automatic test_repeat_wrap();
    go_idle();
    program_all(16'h0001, 16'd3, 16'd20, 16'd40, 16'd60, 16'd10);
    // the hold runs across the timestamp wrap
    now_ms = 32'hFFFF_FFE0;
    tick(1'b1, 0);  tick(1'b1, 3); tick(1'b1, 37); tick(1'b1, 20);
    tick(1'b1, 5);  tick(1'b1, 5); tick(1'b0, 1);  tick(1'b0, 3);
    now_ms = '1;
    tick(1'b0, 0);
  endtask

  task automatic test_threshold_extremes();
    go_idle();
    program_all(16'h0001, '0, '0, '0, '0, '0);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    tick(1'b1, 7); tick(1'b0, 0);
    tick(1'b1, 0); tick(1'b1, 0); tick(1'b1, 0); tick(1'b1, 0); tick(1'b0, 0); tick(1'b0, 0);
    go_idle();
    program_all('1, '1, '1, '1, '1, '1);
    tick(1'b1, 5);     tick(1'b1, 65534); tick(1'b1, 1);  tick(1'b1, 65535);
    tick(1'b1, 65535); tick(1'b0, 1);     tick(1'b0, 65535);
  endtask

  task automatic test_receiver_hold_off();
    go_idle();
    program_all(16'h0001, DEBOUNCE_RST, SHORT_MAX_RST, LONG_RST, REPEAT_START_RST,
                REPEAT_PERIOD_RST);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = 1'b1;
    repeat (3) press_gesture();
    sender_pause();
    repeat (2) press_gesture();
  endtask

  task automatic test_random_gestures(int unsigned count);
    int unsigned stop_at, next_cfg;
    thr_t        dbt, smax, lng;
    stop_at  = items_sent + count;
    next_cfg = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        go_idle();
        dbt  = pick_thr(0, 30);
        smax = pick_thr(dbt, dbt + 300);
        lng  = pick_thr(smax, smax + 400);
        program_all(thr_t'($urandom), dbt, smax, lng, pick_thr(0, lng + 500), pick_thr(0, 80));
        if ($urandom_range(0, 3) == 0)
          write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO,
                    thr_t'($urandom));
        if ($urandom_range(0, 4) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
        next_cfg   = items_sent + $urandom_range(80, 200);
      end
      if ($urandom_range(0, 9) == 0) noise_burst();
      else press_gesture();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_repeat_wrap();
    test_threshold_extremes();
    test_receiver_hold_off();
    test_random_gestures(1050);
    go_idle();
    if (mismatches == 0) begin
      $display("[button_press_classifier_top] OK");
    end else begin
      $display("[button_press_classifier_top] ERROR");
    end
    $finish;
  end

endmodule
